[sv/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 17;
  localparam int CNT_W   = 9;
  localparam int IDX_W   = 2;
  localparam int STS_W   = 2;

  localparam logic [IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_BYTES = 2'd1;
  localparam logic [IDX_W-1:0] REG_TOTAL = 2'd2;

  localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 17'd64;
  localparam logic [CNT_W-1:0]   TOTAL_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] BYTES_MAX   = 17'd65536;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [STS_W-1:0]  status;
    logic [CNT_W-1:0]  blocks_free;
  } res_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

endpackage

[sv/fbpa_ctrl.sv]
// Request sequencer for the fixed block pool allocator.
`timescale 1ns / 1ps

module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        state_next = start ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    cmd.capture = (state == ST_IDLE) && start;
    cmd.lookup  = (state == ST_LOOKUP);
    cmd.commit  = (state == ST_COMMIT);
  end

  a_start_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_LOOKUP))
    else $error("accepted transaction did not enter lookup");

  a_lookup_to_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> (state == ST_COMMIT))
    else $error("lookup not followed by commit");

endmodule

[sv/fbpa_datapath.sv]
// Free ring, pointers, counters and result register of the block pool allocator.
`timescale 1ns / 1ps

module fbpa_datapath
  import fbpa_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  req_t             request,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             done,
  output res_t             result
);

  localparam int PW   = $clog2(POOL_DEPTH);
  localparam int MW   = PW + 1;
  localparam int PRW  = PW + BYTES_W;
  localparam int CAP  = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;

  logic [ADDR_W-1:0]  base_address;
  logic [BYTES_W-1:0] block_bytes;
  logic [CNT_W-1:0]   block_total;
  logic [ADDR_W-1:0]  base_address_next;
  logic [BYTES_W-1:0] block_bytes_next;
  logic [CNT_W-1:0]   block_total_next;
  logic               cfg_known;

  logic [ADDR_W-1:0]  ring [POOL_DEPTH];
  logic [ADDR_W-1:0]  ring_q;
  logic [PRW-1:0]     product;

  logic [PW-1:0]      take_pointer;
  logic [PW-1:0]      return_pointer;
  logic [CNT_W-1:0]   free_count;
  logic [MW-1:0]      written_mark;
  req_t               req_q;

  logic [CNT_W-1:0]   pool_n;
  logic [BYTES_W-1:0] stride;
  logic [PW-1:0]      take_adv;
  logic [PW-1:0]      return_adv;
  logic               ring_hit;
  logic               do_alloc;
  logic               do_free;
  logic [ADDR_W-1:0]  alloc_address;

  function automatic logic [CNT_W-1:0] clamp_total(input logic [CNT_W-1:0] bt);
    logic [CNT_W-1:0] n;
    if (bt == '0) begin
      n = CNT_W'(1);
    end else if (32'(bt) > POOL_DEPTH) begin
      n = CNT_W'(CAP);
    end else begin
      n = bt;
    end
    return n;
  endfunction

  always_comb begin
    base_address_next = base_address;
    block_bytes_next  = block_bytes;
    block_total_next  = block_total;
    cfg_known         = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE: begin
          base_address_next = cfg_data;
          cfg_known         = 1'b1;
        end
        REG_BYTES: begin
          block_bytes_next = cfg_data[BYTES_W-1:0];
          cfg_known        = 1'b1;
        end
        REG_TOTAL: begin
          block_total_next = cfg_data[CNT_W-1:0];
          cfg_known        = 1'b1;
        end
        default:   ;
      endcase
    end
  end

  always_comb begin
    pool_n = clamp_total(block_total);
    if (block_bytes == '0) begin
      stride = BYTES_W'(1);
    end else if (block_bytes > BYTES_MAX) begin
      stride = BYTES_MAX;
    end else begin
      stride = block_bytes;
    end
    take_adv   = ((32'(take_pointer) + 1) >= 32'(pool_n)) ? '0
                 : PW'(32'(take_pointer) + 1);
    return_adv = ((32'(return_pointer) + 1) >= 32'(pool_n)) ? '0
                 : PW'(32'(return_pointer) + 1);
    ring_hit      = (32'(take_pointer) < 32'(written_mark));
    alloc_address = ring_hit ? ring_q : (base_address + 32'(product));
    do_alloc      = cmd.commit && (req_q.mode == MODE_ALLOC) && (free_count != '0);
    do_free       = cmd.commit && (req_q.mode == MODE_FREE) && (free_count < pool_n);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      ring_q  <= ring[take_pointer];
      product <= PRW'(take_pointer) * PRW'(stride);
    end
    if (do_free) begin
      ring[return_pointer] <= req_q.release_address;
    end
    if (cmd.capture) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= BASE_RESET;
      block_bytes    <= BYTES_RESET;
      block_total    <= TOTAL_RESET;
      take_pointer   <= '0;
      return_pointer <= '0;
      written_mark   <= '0;
      free_count     <= clamp_total(TOTAL_RESET);
      done           <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cfg_known) begin
        base_address   <= base_address_next;
        block_bytes    <= block_bytes_next;
        block_total    <= block_total_next;
        take_pointer   <= '0;
        return_pointer <= '0;
        written_mark   <= '0;
        free_count     <= clamp_total(block_total_next);
      end else if (do_alloc) begin
        take_pointer <= take_adv;
        free_count   <= free_count - CNT_W'(1);
      end else if (do_free) begin
        return_pointer <= return_adv;
        free_count     <= free_count + CNT_W'(1);
        if (32'(return_pointer) >= 32'(written_mark)) begin
          written_mark <= MW'(32'(return_pointer) + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      priority if (do_alloc) begin
        result.block_address <= alloc_address;
        result.status        <= STATUS_OK;
        result.blocks_free   <= free_count - CNT_W'(1);
      end else if (do_free) begin
        result.block_address <= '0;
        result.status        <= STATUS_OK;
        result.blocks_free   <= free_count + CNT_W'(1);
      end else begin
        result.block_address <= '0;
        result.status        <= (req_q.mode == MODE_ALLOC) ? STATUS_EMPTY : STATUS_FULL;
        result.blocks_free   <= free_count;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool_n)
    else $error("free count above pool size");

  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    32'(written_mark) <= POOL_DEPTH)
    else $error("written mark beyond ring depth");

  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.commit))
    else $error("result strobe without commit");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_FULL) |-> (result.blocks_free == pool_n))
    else $error("full reported below pool size");

endmodule

[sv/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: sequencer, datapath and ports.
//
//   channel   handshake               payload
//   request   start, busy             request (req_t)
//   result    done (one-cycle strobe) result (res_t)
//   config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// Each transaction steps through capture, registered ring read and stride
// multiply, and commit; busy holds off a new one until the sequencer is back
// in idle. The result strobe comes in the cycle after commit, while the next
// transaction may already be accepted.
// rst is synchronous; the ring gets no clearing pass, a written mark covers it.
// The receiver cannot stall; cfg_ready is low while busy.
`timescale 1ns / 1ps

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             done,
  output res_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  cmd_t cmd;
  logic cfg_write;

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  fbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fbpa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule

[sim/pool_reply_checker.sv]
// Reply checker for the fixed block pool allocator: watches its channels, predicts, compares.
`timescale 1ns / 1ps

module pool_reply_checker
  import fbpa_pkg::*;
#(
  parameter int POOL_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  req_t             request,
  input  logic             done,
  input  res_t             result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output int               failures,
  output int               outstanding
);

  logic [ADDR_W-1:0]  base_reg;
  logic [BYTES_W-1:0] bytes_reg;
  logic [CNT_W-1:0]   total_reg;
  logic [ADDR_W-1:0]  ring [POOL_DEPTH];
  int unsigned        take_idx;
  int unsigned        give_idx;
  int unsigned        free_blocks;
  int unsigned        mark;
  res_t               predicted_replies [$];

  function automatic int unsigned pool_blocks();
    int unsigned n;
    n = total_reg;
    if (n < 1) n = 1;
    if (n > POOL_DEPTH) n = POOL_DEPTH;
    return n;
  endfunction

  function automatic int unsigned block_stride();
    int unsigned s;
    s = bytes_reg;
    if (s < 1) s = 1;
    if (s > BYTES_MAX) s = BYTES_MAX;
    return s;
  endfunction

  function automatic void restart_pool();
    take_idx    = 0;
    give_idx    = 0;
    mark        = 0;
    free_blocks = pool_blocks();
  endfunction

  function automatic logic [ADDR_W-1:0] entry_address(int unsigned idx);
    logic [63:0] sum;
    if (idx < mark) return ring[idx];
    sum = 64'(base_reg) + 64'(idx) * 64'(block_stride());
    return sum[ADDR_W-1:0];
  endfunction

  function automatic int unsigned step_ptr(int unsigned p, int unsigned n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function automatic res_t serve(req_t rq);
    res_t        r;
    int unsigned n;
    n = pool_blocks();
    r = '0;
    r.status = STATUS_OK;
    if (rq.mode == MODE_ALLOC) begin
      if (free_blocks > 0) begin
        r.block_address = entry_address(take_idx);
        take_idx = step_ptr(take_idx, n);
        free_blocks--;
      end else begin
        r.status = STATUS_EMPTY;
      end
    end else begin
      if (free_blocks >= n) begin
        r.status = STATUS_FULL;
      end else begin
        ring[give_idx] = rq.release_address;
        if (give_idx >= mark) mark = give_idx + 1;
        give_idx = step_ptr(give_idx, n);
        free_blocks++;
      end
    end
    r.blocks_free = free_blocks[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    logic restart;
    if (rst) begin
      base_reg  = BASE_RESET;
      bytes_reg = BYTES_RESET;
      total_reg = TOTAL_RESET;
      restart_pool();
      predicted_replies.delete();
      failures = 0;
    end else begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          $display("%t reply with none pending: expected nothing actual %h", $time, result);
          failures++;
        end else begin
          want = predicted_replies.pop_front();
          if (result.block_address !== want.block_address) begin
            $display("%t block_address mismatch: expected %h actual %h", $time,
                     want.block_address, result.block_address);
            failures++;
          end
          if (result.status !== want.status) begin
            $display("%t status mismatch: expected %0d actual %0d", $time,
                     want.status, result.status);
            failures++;
          end
          if (result.blocks_free !== want.blocks_free) begin
            $display("%t blocks_free mismatch: expected %0d actual %0d", $time,
                     want.blocks_free, result.blocks_free);
            failures++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        restart = 1'b1;
        case (cfg_index)
          REG_BASE:  base_reg  = cfg_data;
          REG_BYTES: bytes_reg = cfg_data[BYTES_W-1:0];
          REG_TOTAL: total_reg = cfg_data[CNT_W-1:0];
          default:   restart   = 1'b0;
        endcase
        if (restart) restart_pool();
      end
      if (start && !busy) predicted_replies.push_back(serve(request));
    end
    outstanding <= predicted_replies.size();
  end

endmodule

[sim/tb_fixed_block_pool_allocator.sv]
// Testbench top for the fixed block pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int               CYCLE_LIMIT = 200000;
  localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;

  logic             clk;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  req_t             request   = '0;
  logic             done;
  res_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = REG_BASE;
  logic [31:0]      cfg_data  = '0;
  int               failures;
  int               outstanding;
  int               cycles    = 0;
  int               idle_pct  = 0;

  fixed_block_pool_allocator uut (.*);

  pool_reply_checker reply_watch (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic m, input logic [ADDR_W-1:0] a);
    start   <= 1'b1;
    request <= '{mode: m, release_address: a};
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] bytes,
                           input logic [31:0] total);
    drain();
    write_reg(REG_BASE, base);
    write_reg(REG_BYTES, bytes);
    write_reg(REG_TOTAL, total);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int   pool;
    int   bsz;
    int   run_left;
    logic grab;
    logic m;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 31;

    // reset settings: full pool, computed addresses, refill to full
    send(MODE_FREE, 32'hFFFF_FFFF);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'h0000_0000);
    send(MODE_FREE, 32'hFFFF_FFFF);
    send(MODE_FREE, 32'hA5A5_A5A5);

    // unknown register: pool must keep its state
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send(MODE_ALLOC, 32'h0);

    // zero size and zero count act as one
    configure(32'hFFFF_FFFF, 32'h0, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'h5A5A_5A5A);
    send(MODE_FREE, 32'h1234_5678);
    send(MODE_ALLOC, 32'h0);

    // oversized stride clamps, addresses wrap past the top
    configure(32'hFFFF_0000, 32'h0001_FFFF, 32'd3);
    repeat (4) send(MODE_ALLOC, 32'h0);
    repeat (3) send(MODE_FREE, $urandom);

    // largest legal stride, oversized count clamps to the ring depth
    configure(32'h1234_5678, 32'd65536, 32'd511);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'hFFFF_FFFF);
    send(MODE_FREE, 32'h0);
    send(MODE_FREE, 32'h0);

    for (int seg = 0; seg < 9; seg++) begin
      case ($urandom_range(3))
        0:       bsz = 1;
        1:       bsz = $urandom_range(65536, 131071);
        2:       bsz = $urandom_range(0, 64);
        default: bsz = $urandom_range(1, 65536);
      endcase
      case ($urandom_range(3))
        0:       pool = $urandom_range(0, 4);
        1:       pool = $urandom_range(5, 16);
        2:       pool = $urandom_range(17, 511);
        default: pool = $urandom_range(1, 8);
      endcase
      configure($urandom, {15'($urandom), 17'(bsz)}, {23'($urandom), 9'(pool)});
      idle_pct = (seg < 3) ? 31 : (seg < 6) ? 64 : 0;
      run_left = 0;
      grab     = 1'b1;
      for (int k = 0; k < 50; k++) begin
        if (run_left == 0) begin
          if ($urandom_range(99) < 60) grab = ~grab;
          run_left = $urandom_range(1, 2 * ((pool > 24) ? 24 : pool) + 2);
        end
        run_left--;
        if ($urandom_range(99) < 10) m = 1'($urandom);
        else m = grab ? MODE_ALLOC : MODE_FREE;
        case ($urandom_range(9))
          0:       send(m, 32'h0);
          1:       send(m, 32'hFFFF_FFFF);
          default: send(m, $urandom);
        endcase
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
sv/fbpa_pkg.sv
sv/fbpa_ctrl.sv
sv/fbpa_datapath.sv
sv/fixed_block_pool_allocator.sv
sim/pool_reply_checker.sv
sim/tb_fixed_block_pool_allocator.sv
